// ----- rtl/szc_pkg.sv -----
// shared types, constants and the cordic angle table for the scan zone check
package szc_pkg;

  localparam int unsigned MaxBeams   = 2048;
  localparam int unsigned BeamW      = $clog2(MaxBeams);
  localparam int unsigned CordicIter = 16;
  localparam int unsigned IterW      = $clog2(CordicIter);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CordW      = 27;
  localparam int unsigned ZW         = 34;
  localparam int unsigned PosW       = 19;
  localparam int unsigned ProdW      = 38;
  localparam logic [14:0] InvGain    = 15'd19899;

  localparam logic [CfgIdxW-1:0] RegVertexA = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVertexB = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVertexC = 3'd2;
  localparam logic [CfgIdxW-1:0] RegVertexD = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFloor   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCeil    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegAStart  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegAStep   = 3'd7;

  typedef struct packed {
    logic             load;
    logic             init;
    logic             rotate;
    logic             round;
    logic             edge_mul;
    logic             edge_cmp;
    logic             finish;
    logic [IterW-1:0] iter;
    logic [1:0]       edge_idx;
  } szc_cmd_t;

  typedef struct packed {
    logic qual;
    logic out_free;
  } szc_stat_t;

  function automatic logic signed [ZW-1:0] cordic_atan(input logic [IterW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 34'sd536870912;
      4'd1:    v = 34'sd316933406;
      4'd2:    v = 34'sd167458907;
      4'd3:    v = 34'sd85004756;
      4'd4:    v = 34'sd42667331;
      4'd5:    v = 34'sd21354465;
      4'd6:    v = 34'sd10679838;
      4'd7:    v = 34'sd5340245;
      4'd8:    v = 34'sd2670163;
      4'd9:    v = 34'sd1335087;
      4'd10:   v = 34'sd667544;
      4'd11:   v = 34'sd333772;
      4'd12:   v = 34'sd166886;
      4'd13:   v = 34'sd83443;
      4'd14:   v = 34'sd41722;
      4'd15:   v = 34'sd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/szc_if.sv -----
// handshake channels for range samples and zone results
interface szc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_sample;
  logic        sample_valid;
  logic        last_sample;
  modport source (output valid, range_sample, sample_valid, last_sample, input ready);
  modport sink (input valid, range_sample, sample_valid, last_sample, output ready);
endinterface

interface szc_out_if;
  logic valid;
  logic ready;
  logic point_inside;
  logic obstacle_so_far;
  logic scan_done;
  modport source (output valid, point_inside, obstacle_so_far, scan_done, input ready);
  modport sink (input valid, point_inside, obstacle_so_far, scan_done, output ready);
endinterface

// ----- rtl/szc_ctrl.sv -----
// sequencer for sample load, cordic rotation, edge tests and result hand-off
module szc_ctrl
  import szc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  szc_stat_t stat_i,
  output szc_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StInit   = 7'b0000010,
    StRotate = 7'b0000100,
    StRound  = 7'b0001000,
    StMul    = 7'b0010000,
    StCmp    = 7'b0100000,
    StFinish = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic [1:0]       edge_q, edge_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    edge_d  = edge_q;
    cmd_o   = '0;
    cmd_o.iter     = iter_q;
    cmd_o.edge_idx = edge_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        iter_d     = '0;
        edge_d     = '0;
        state_d    = stat_i.qual ? StRotate : StFinish;
      end
      StRotate: begin
        cmd_o.rotate = 1'b1;
        iter_d       = iter_q + 1'b1;
        if (iter_q == IterW'(CordicIter - 1)) state_d = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        state_d     = StMul;
      end
      StMul: begin
        cmd_o.edge_mul = 1'b1;
        state_d        = StCmp;
      end
      StCmp: begin
        cmd_o.edge_cmp = 1'b1;
        edge_d         = edge_q + 1'b1;
        state_d        = (edge_q == 2'd3) ? StFinish : StMul;
      end
      StFinish: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iter_q  <= '0;
      edge_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      edge_q  <= edge_d;
    end
  end

endmodule

// ----- rtl/szc_dp.sv -----
// config registers, cordic datapath, polygon edge tests and result register
module szc_dp
  import szc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [15:0]         range_sample_i,
  input  logic                sample_valid_i,
  input  logic                last_sample_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                point_inside_o,
  output logic                obstacle_so_far_o,
  output logic                scan_done_o,
  input  szc_cmd_t            cmd_i,
  output szc_stat_t           stat_o
);

  logic [31:0] vert_q [4];
  logic [15:0] floor_q, ceil_q, astart_q, astep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q[0] <= 32'd100664832;
      vert_q[1] <= 32'd100727296;
      vert_q[2] <= 32'd65229;
      vert_q[3] <= 32'd307;
      floor_q   <= 16'd0;
      ceil_q    <= 16'hFFFF;
      astart_q  <= 16'd32768;
      astep_q   <= 16'd104;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegVertexA: vert_q[0] <= cfg_data_i;
        RegVertexB: vert_q[1] <= cfg_data_i;
        RegVertexC: vert_q[2] <= cfg_data_i;
        RegVertexD: vert_q[3] <= cfg_data_i;
        RegFloor:   floor_q   <= cfg_data_i[15:0];
        RegCeil:    ceil_q    <= cfg_data_i[15:0];
        RegAStart:  astart_q  <= cfg_data_i[15:0];
        RegAStep:   astep_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // per-sample registers
  logic [15:0]              r_q, theta_q;
  logic                     last_q, qual_q, flip_q, in_q;
  logic signed [CordW-1:0]  x_q, y_q;
  logic signed [ZW-1:0]     z_q;
  logic signed [PosW-1:0]   px_q, py_q;
  logic signed [ProdW-1:0]  lhs_q;
  logic [BeamW-1:0]         beam_q;
  logic                     obs_q;
  logic                     ovalid_q, oin_q, oobs_q, odone_q;

  logic [26:0] theta_prod;
  assign theta_prod = 27'(beam_q) * 27'(astep_q);

  // fold the left half plane onto the right
  logic        fold;
  logic [15:0] theta_f;
  logic [30:0] r_scaled;
  assign fold     = (theta_q >= 16'd16384) && (theta_q < 16'd49152);
  assign theta_f  = fold ? (theta_q + 16'd32768) : theta_q;
  assign r_scaled = 31'(r_q) * 31'(InvGain);

  logic signed [CordW-1:0] dx, dy;
  logic signed [ZW-1:0]    atan_v;
  assign dx     = y_q >>> cmd_i.iter;
  assign dy     = x_q >>> cmd_i.iter;
  assign atan_v = cordic_atan(cmd_i.iter);

  logic signed [CordW-1:0] xr, yr;
  assign xr = (x_q + CordW'(128)) >>> 8;
  assign yr = (y_q + CordW'(128)) >>> 8;

  // edge j runs from vertex k = j-1 to vertex j
  logic [1:0]              kidx;
  logic signed [15:0]      vxj, vyj, vxk, vyk;
  logic signed [ProdW-1:0] dvy, ex, ekx, eyy, rhs;
  logic                    straddle, crossing;
  assign kidx     = cmd_i.edge_idx - 2'd1;
  assign vxj      = $signed(vert_q[cmd_i.edge_idx][31:16]);
  assign vyj      = $signed(vert_q[cmd_i.edge_idx][15:0]);
  assign vxk      = $signed(vert_q[kidx][31:16]);
  assign vyk      = $signed(vert_q[kidx][15:0]);
  assign dvy      = ProdW'(vyk) - ProdW'(vyj);
  assign ex       = ProdW'(px_q) - ProdW'(vxj);
  assign ekx      = ProdW'(vxk) - ProdW'(vxj);
  assign eyy      = ProdW'(py_q) - ProdW'(vyj);
  assign rhs      = ekx * eyy;
  assign straddle = ((ProdW'(vyj) > ProdW'(py_q)) != (ProdW'(vyk) > ProdW'(py_q)));
  assign crossing = (dvy > 0) ? (lhs_q < rhs) : (lhs_q > rhs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q     <= range_sample_i;
      last_q  <= last_sample_i;
      qual_q  <= sample_valid_i && (range_sample_i >= floor_q) && (range_sample_i <= ceil_q);
      theta_q <= astart_q + theta_prod[15:0];
    end
    if (cmd_i.init) begin
      flip_q <= fold;
      x_q    <= CordW'(r_scaled[30:7]);
      y_q    <= '0;
      z_q    <= ZW'($signed(theta_f)) <<< 16;
      in_q   <= 1'b0;
    end
    if (cmd_i.rotate) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
    end
    if (cmd_i.round) begin
      px_q <= flip_q ? -PosW'(xr) : PosW'(xr);
      py_q <= flip_q ? -PosW'(yr) : PosW'(yr);
    end
    if (cmd_i.edge_mul) lhs_q <= ex * dvy;
    if (cmd_i.edge_cmp && straddle && crossing) in_q <= ~in_q;
    if (cmd_i.finish) begin
      oin_q   <= qual_q && in_q;
      oobs_q  <= obs_q || (qual_q && in_q);
      odone_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q   <= '0;
      obs_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        ovalid_q <= 1'b1;
        if (last_q) begin
          beam_q <= '0;
          obs_q  <= 1'b0;
        end else begin
          beam_q <= (beam_q == BeamW'(MaxBeams - 1)) ? '0 : beam_q + 1'b1;
          obs_q  <= obs_q || (qual_q && in_q);
        end
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign stat_o.qual       = qual_q;
  assign stat_o.out_free   = !ovalid_q || out_ready_i;
  assign out_valid_o       = ovalid_q;
  assign point_inside_o    = oin_q;
  assign obstacle_so_far_o = oobs_q;
  assign scan_done_o       = odone_q;

endmodule

// ----- rtl/scan_polygon_zone_check.sv -----
// top level of the lidar scan zone check against a four-corner polygon
//
//  channel   dir  payload                                       transfer when
//  in_chan   in   range_sample, sample_valid, last_sample       valid && ready
//  out_chan  out  point_inside, obstacle_so_far, scan_done      valid && ready
//  cfg       in   cfg_idx_i, cfg_data_i                         cfg_we_i
//
// an accepted sample has its result valid once it has passed through init,
// 16 cordic rotations on one shared shift-add unit, round, a multiply and a
// compare step per polygon edge, and finish; the next sample is taken only
// after finish, back in idle. a rejected sample goes from init straight to
// finish. reset returns the corner, range and angle registers to their
// defaults and clears the beam counter and the obstacle flag. a
// waiting result does not block the next sample; a second result waits in the
// finish step until the first one is taken.
module scan_polygon_zone_check
  import szc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  szc_in_if.sink              in_chan_i,
  szc_out_if.source           out_chan_o
);

  szc_cmd_t  cmd;
  szc_stat_t stat;

  szc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_chan_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  szc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .range_sample_i    (in_chan_i.range_sample),
    .sample_valid_i    (in_chan_i.sample_valid),
    .last_sample_i     (in_chan_i.last_sample),
    .out_ready_i       (out_chan_o.ready),
    .out_valid_o       (out_chan_o.valid),
    .point_inside_o    (out_chan_o.point_inside),
    .obstacle_so_far_o (out_chan_o.obstacle_so_far),
    .scan_done_o       (out_chan_o.scan_done),
    .cmd_i             (cmd),
    .stat_o            (stat)
  );

endmodule
